// File: src/fmipd_pkg.sv
// shared types and constants of the four-motor incremental pid drive
package fmipd_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_BITS  = 2;
  localparam int SPEED_BITS  = 16;
  localparam int GAIN_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int DUTY_FRAC   = 8;
  localparam int DUTY_BITS   = 24;
  localparam int ERR_BITS    = 18;
  localparam int DECAY_FLOOR = 50;

  // floor(t / 5) == (t * DECAY_RECIP) >> DECAY_SHIFT for t below 2**22
  localparam int DECAY_SHIFT = 25;
  localparam logic signed [24:0] DECAY_RECIP = 25'sd6710887;
  localparam logic [DUTY_BITS-1:0] DECAY_LIMIT = DUTY_BITS'(DECAY_FLOOR << DUTY_FRAC);

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INT_GAIN      = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_REVERSE_LIMIT = 3'd3,
    REG_INC_MAX       = 3'd4,
    REG_INC_MIN       = 3'd5,
    REG_DUTY_MAX      = 3'd6,
    REG_DEAD_OFFSET   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [MOTOR_BITS-1:0]        motor;
    logic signed [SPEED_BITS-1:0] measured_speed;
    logic signed [SPEED_BITS-1:0] target_speed;
  } in_item_t;

  typedef struct packed {
    logic [MOTOR_BITS-1:0] motor_out;
    logic                  drive_fwd;
    logic                  drive_rev;
    logic [15:0]           compare_value;
    logic                  compare_written;
  } out_item_t;

endpackage

// File: src/fmipd_in_if.sv
// input channel: motor index with measured and target speed
interface fmipd_in_if import fmipd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/fmipd_out_if.sv
// output channel: direction enables and timer compare value
interface fmipd_out_if import fmipd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/four_motor_incremental_pid_drive.sv
// Four-channel incremental PID motor drive. Each transaction names a motor with its
// measured and target speed; one result per transaction gives the direction enables
// and the timer compare value. All multiplication runs through one 24 x 25 bit multiplier
// under a small sequencer, one transaction at a time. A driving update passes through
// setup, four multiplier passes, a clamp step, a duty update and a hand-over to the output
// register; a decaying update passes through setup, a multiply, a finishing step and the
// hand-over; a zero setpoint on a motor with no history goes from setup to the hand-over. A new transaction is accepted
// while the previous result still waits in the output register; the hand-over waits
// for that register to drain. No clearing pass is needed after reset.
module four_motor_incremental_pid_drive
  import fmipd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  fmipd_in_if.sink            in_item,
  fmipd_out_if.source         out_item
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SETUP     = 11'b000_0000_0010,
    S_MUL_I     = 11'b000_0000_0100,
    S_MUL_D     = 11'b000_0000_1000,
    S_MUL_PL    = 11'b000_0001_0000,
    S_MUL_PH    = 11'b000_0010_0000,
    S_CLAMP     = 11'b000_0100_0000,
    S_UPDATE    = 11'b000_1000_0000,
    S_DECAY_MUL = 11'b001_0000_0000,
    S_DECAY_FIN = 11'b010_0000_0000,
    S_FIN       = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [GAIN_BITS-1:0] prop_gain, int_gain, deriv_gain;
  logic [14:0]          reverse_limit;
  logic signed [15:0]   inc_max, inc_min;
  logic [15:0]          duty_max, dead_offset;

  // per-motor state
  logic signed [SPEED_BITS-1:0] prev_target    [MOTOR_COUNT];
  logic signed [ERR_BITS-1:0]   last_error     [MOTOR_COUNT];
  logic signed [ERR_BITS-1:0]   older_error    [MOTOR_COUNT];
  logic [DUTY_BITS-1:0]         duty_forward   [MOTOR_COUNT];
  logic [DUTY_BITS-1:0]         duty_reverse   [MOTOR_COUNT];
  dir_t                         last_direction [MOTOR_COUNT];

  // working registers
  logic [MOTOR_BITS-1:0]        m_q;
  logic signed [SPEED_BITS-1:0] meas_q, tgt_q;
  logic signed [ERR_BITS-1:0]   e_q, e_next;
  logic signed [ERR_BITS:0]     d2e_q, d2e_next;
  dir_t                         dir_q, dir_next;
  logic signed [51:0]           acc, acc_next;
  logic signed [17:0]           inner_hi, inner_hi_next;
  logic signed [23:0]           inc_q, inc_next;
  out_item_t                    res_q, res_next;
  logic                         out_valid, out_valid_next;
  out_item_t                    out_q;

  // shared multiplier
  logic [23:0]        mul_a;
  logic signed [24:0] mul_b;
  logic signed [49:0] prod;

  logic                  out_free;
  logic                  keep_target;
  logic [SPEED_BITS:0]   abs_meas, abs_sp;
  logic signed [SPEED_BITS-1:0] setpoint;
  logic                  reversal;
  logic signed [ERR_BITS-1:0] e1, e2, de;
  logic [DUTY_BITS-1:0]  duty_cur, duty_new;
  logic signed [25:0]    duty_sum, duty_top;
  logic [24:0]           decay_in;
  logic [23:0]           decay_q;
  logic [16:0]           cmp_sum;
  logic signed [43:0]    inc_full, inc_hi, inc_lo, inc_lim;

  function automatic logic [SPEED_BITS:0] speed_mag(logic signed [SPEED_BITS-1:0] v);
    logic signed [SPEED_BITS:0] w;
    w = {v[SPEED_BITS-1], v};
    if (v[SPEED_BITS-1]) begin
      return (SPEED_BITS+1)'(0) - w;
    end
    return w;
  endfunction

  assign prod     = $signed({1'b0, mul_a}) * mul_b;
  assign out_free = !out_valid || out_item.ready;

  assign in_item.ready  = (state == S_IDLE);
  assign out_item.valid = out_valid;
  assign out_item.data  = out_q;

  assign e1       = last_error[m_q];
  assign e2       = older_error[m_q];
  assign duty_cur = (dir_q == DIR_FWD) ? duty_forward[m_q] : duty_reverse[m_q];

  always_comb begin
    abs_meas    = speed_mag(meas_q);
    reversal    = (!prev_target[m_q][SPEED_BITS-1] && prev_target[m_q] != '0 &&
                   tgt_q[SPEED_BITS-1]) ||
                  (prev_target[m_q][SPEED_BITS-1] && !tgt_q[SPEED_BITS-1] && tgt_q != '0);
    keep_target = (abs_meas < {2'b00, reverse_limit}) || !reversal;
    setpoint    = keep_target ? tgt_q : '0;
    abs_sp      = speed_mag(setpoint);
    de          = e_q - e1;

    state_next     = state;
    out_valid_next = out_valid;
    e_next         = e_q;
    d2e_next       = d2e_q;
    dir_next       = dir_q;
    acc_next       = acc;
    inner_hi_next  = inner_hi;
    inc_next       = inc_q;
    res_next       = res_q;
    mul_a          = '0;
    mul_b          = '0;
    duty_new       = duty_cur;
    duty_sum       = '0;
    duty_top       = $signed({2'b00, duty_max, 8'h00});
    decay_in       = {1'b0, duty_cur} + 25'd19;
    decay_q        = '0;
    cmp_sum        = '0;
    inc_full       = acc[51:8];
    inc_hi         = {{20{inc_max[15]}}, inc_max, 8'h00};
    inc_lo         = {{20{inc_min[15]}}, inc_min, 8'h00};
    inc_lim        = '0;

    if (out_valid && out_item.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (in_item.valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        e_next = $signed({1'b0, abs_sp}) - $signed({1'b0, abs_meas});
        res_next = '0;
        res_next.motor_out = m_q;
        if (setpoint != '0) begin
          dir_next   = setpoint[SPEED_BITS-1] ? DIR_REV : DIR_FWD;
          state_next = S_MUL_I;
        end else if (last_direction[m_q] == DIR_NONE) begin
          state_next = S_FIN;
        end else begin
          dir_next   = last_direction[m_q];
          state_next = S_DECAY_MUL;
        end
      end
      S_MUL_I: begin
        mul_a    = {8'h00, int_gain};
        mul_b    = {{7{e_q[ERR_BITS-1]}}, e_q};
        acc_next = {{26{de[ERR_BITS-1]}}, de, 8'h00} + {{2{prod[49]}}, prod};
        d2e_next = {e_q[ERR_BITS-1], e_q} - {e1, 1'b0} + {e2[ERR_BITS-1], e2};
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        mul_a      = {8'h00, deriv_gain};
        mul_b      = {{6{d2e_q[ERR_BITS]}}, d2e_q};
        acc_next   = acc + {{2{prod[49]}}, prod};
        state_next = S_MUL_PL;
      end
      S_MUL_PL: begin
        // low half of the inner sum, unsigned
        mul_a         = {8'h00, prop_gain};
        mul_b         = {7'b0, acc[17:0]};
        acc_next      = {{2{prod[49]}}, prod};
        inner_hi_next = acc[35:18];
        state_next    = S_MUL_PH;
      end
      S_MUL_PH: begin
        mul_a      = {8'h00, prop_gain};
        mul_b      = {{7{inner_hi[17]}}, inner_hi};
        acc_next   = acc + {prod[33:0], 18'h0};
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        // upper clamp first, so the lower one wins when they cross
        inc_lim    = (inc_full > inc_hi) ? inc_hi : inc_full;
        inc_lim    = (inc_lim < inc_lo) ? inc_lo : inc_lim;
        inc_next   = inc_lim[23:0];
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        duty_sum = $signed({2'b00, duty_cur}) + $signed({{2{inc_q[23]}}, inc_q});
        priority if (duty_sum >= duty_top) begin
          duty_new = {duty_max, 8'h00};
        end else if (duty_sum <= 26'sd0) begin
          duty_new = '0;
        end else begin
          duty_new = duty_sum[23:0];
        end
        cmp_sum = {1'b0, duty_new[23:8]} + {1'b0, dead_offset};
        res_next.drive_fwd       = (dir_q == DIR_FWD);
        res_next.drive_rev       = (dir_q == DIR_REV);
        res_next.compare_value   = cmp_sum[16] ? 16'hFFFF : cmp_sum[15:0];
        res_next.compare_written = 1'b1;
        state_next = S_FIN;
      end
      S_DECAY_MUL: begin
        // ceil(duty / 20) as floor(floor((duty + 19) / 4) / 5)
        mul_a      = {1'b0, decay_in[24:2]};
        mul_b      = DECAY_RECIP;
        acc_next   = {{2{prod[49]}}, prod};
        state_next = S_DECAY_FIN;
      end
      S_DECAY_FIN: begin
        decay_q  = acc[DECAY_SHIFT+23:DECAY_SHIFT];
        duty_new = duty_cur - decay_q;
        if (duty_new < DECAY_LIMIT) begin
          duty_new = '0;
        end
        res_next.drive_fwd       = (dir_q == DIR_FWD);
        res_next.drive_rev       = (dir_q == DIR_REV);
        res_next.compare_value   = duty_new[23:8];
        res_next.compare_written = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control, configuration and per-motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      prop_gain     <= 16'd1024;
      int_gain      <= 16'd1024;
      deriv_gain    <= 16'd0;
      reverse_limit <= 15'd0;
      inc_max       <= 16'sd100;
      inc_min       <= -16'sd100;
      duty_max      <= 16'd1000;
      dead_offset   <= 16'd0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        prev_target[i]    <= '0;
        last_error[i]     <= '0;
        older_error[i]    <= '0;
        duty_forward[i]   <= '0;
        duty_reverse[i]   <= '0;
        last_direction[i] <= DIR_NONE;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;

      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:     prop_gain     <= cfg_wr_data;
          REG_INT_GAIN:      int_gain      <= cfg_wr_data;
          REG_DERIV_GAIN:    deriv_gain    <= cfg_wr_data;
          REG_REVERSE_LIMIT: reverse_limit <= cfg_wr_data[14:0];
          REG_INC_MAX:       inc_max       <= cfg_wr_data;
          REG_INC_MIN:       inc_min       <= cfg_wr_data;
          REG_DUTY_MAX:      duty_max      <= cfg_wr_data;
          REG_DEAD_OFFSET:   dead_offset   <= cfg_wr_data;
          default: ;
        endcase
      end

      if (state == S_SETUP && keep_target) begin
        prev_target[m_q] <= tgt_q;
      end
      if (state == S_MUL_I) begin
        older_error[m_q] <= e1;
        last_error[m_q]  <= e_q;
      end
      if (state == S_UPDATE || state == S_DECAY_FIN) begin
        last_direction[m_q] <= dir_q;
        if (dir_q == DIR_FWD) begin
          duty_forward[m_q] <= duty_new;
          duty_reverse[m_q] <= '0;
        end else begin
          duty_reverse[m_q] <= duty_new;
          duty_forward[m_q] <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      m_q    <= in_item.data.motor;
      meas_q <= in_item.data.measured_speed;
      tgt_q  <= in_item.data.target_speed;
    end
    e_q      <= e_next;
    d2e_q    <= d2e_next;
    dir_q    <= dir_next;
    acc      <= acc_next;
    inner_hi <= inner_hi_next;
    inc_q    <= inc_next;
    res_q    <= res_next;
    if (state == S_FIN && out_free) begin
      out_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  for (genvar i = 0; i < MOTOR_COUNT; i++) begin : g_chk
    a_one_direction: assert property (@(posedge clk) disable iff (rst)
      !(duty_forward[i] != '0 && duty_reverse[i] != '0))
      else $error("both duties of one motor are nonzero");
    a_fwd_history: assert property (@(posedge clk) disable iff (rst)
      duty_forward[i] != '0 |-> last_direction[i] == DIR_FWD)
      else $error("forward duty held without forward history");
  end

  a_result_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result presented outside the hand-over");

  a_idle_result_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_q.compare_written |->
      !out_q.drive_fwd && !out_q.drive_rev && out_q.compare_value == '0)
    else $error("unwritten result carries drive values");

  a_inc_floor: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> inc_q >= $signed({inc_min, 8'h00}))
    else $error("increment below the lower clamp");
`endif

endmodule

// File: tb/four_motor_incremental_pid_drive_tb.sv
// self-checking testbench for the four-motor incremental pid drive
module four_motor_incremental_pid_drive_tb
  import fmipd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    LATENCY_WAIT   = 12;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    HOLD_CYCLES    = 300;
  localparam int    HOLD_AFTER     = 500;
  localparam int    REPORT_CAP     = 40;
  localparam longint DECAY_NUM     = 19;
  localparam longint DECAY_DEN     = 20;
  localparam longint INNER_CLIP    = 64'sd1 <<< 46;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_wr_data = '0;

  fmipd_in_if  in_ch ();
  fmipd_out_if out_ch ();

  four_motor_incremental_pid_drive uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_ch),
    .out_item    (out_ch)
  );

  always #6 clk = ~clk;

  // settings as the block holds them, reset values first
  longint kp = 1024;
  longint ki = 1024;
  longint kd = 0;
  longint turn_speed = 0;
  longint inc_hi = 100;
  longint inc_lo = -100;
  longint duty_top = 1000;
  longint cmp_offset = 0;

  // per-motor controller state
  longint held_target [MOTOR_COUNT];
  longint err_last    [MOTOR_COUNT];
  longint err_older   [MOTOR_COUNT];
  longint duty_fwd    [MOTOR_COUNT];
  longint duty_rev    [MOTOR_COUNT];
  dir_t   drive_dir   [MOTOR_COUNT];

  // speed each motor is currently being steered towards by the generator
  longint plan_speed [MOTOR_COUNT];

  in_item_t  speed_requests [$];
  out_item_t expected_drives [$];

  int items_queued = 0;
  int items_taken = 0;
  int mismatch_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int recv_draw = 0;
  int quiet_cycles = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit sink_hold = 1'b0;

  initial begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      held_target[m] = 0;
      err_last[m] = 0;
      err_older[m] = 0;
      duty_fwd[m] = 0;
      duty_rev[m] = 0;
      drive_dir[m] = DIR_NONE;
      plan_speed[m] = 400;
    end
  end

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint pick(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  function automatic logic signed [15:0] to_speed(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int draw_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // incremental pid step on magnitudes, returns the clamped Q.8 increment
  function automatic longint pid_step(input int m, input longint sp, input longint meas);
    longint e;
    longint de;
    longint d2e;
    longint inner;
    longint inc;
    e = magnitude(sp) - magnitude(meas);
    de = e - err_last[m];
    d2e = e - 2 * err_last[m] + err_older[m];
    inner = de * 256 + ki * e + kd * d2e;
    if (inner > INNER_CLIP) inner = INNER_CLIP;
    if (inner < -INNER_CLIP) inner = -INNER_CLIP;
    inc = (kp * inner) >>> 8;
    err_older[m] = err_last[m];
    err_last[m] = e;
    if (inc > inc_hi * 256) inc = inc_hi * 256;
    if (inc < inc_lo * 256) inc = inc_lo * 256;
    return inc;
  endfunction

  function automatic longint clamp_duty(input longint d);
    longint top;
    top = duty_top <<< DUTY_FRAC;
    if (d >= top) d = top;
    if (d <= 0) d = 0;
    return d;
  endfunction

  function automatic logic [15:0] compare_of(input longint d, input longint off);
    longint c;
    c = (d >>> DUTY_FRAC) + off;
    return (c > 65535) ? 16'hFFFF : c[15:0];
  endfunction

  function automatic longint decayed(input longint d);
    d = (d * DECAY_NUM) / DECAY_DEN;
    if (d < (longint'(DECAY_FLOOR) <<< DUTY_FRAC)) d = 0;
    return d;
  endfunction

  task automatic predict_drive(input in_item_t it);
    out_item_t res;
    int m;
    longint meas;
    longint tgt;
    longint sp;
    bit reversal;
    m = it.motor;
    meas = $signed(it.measured_speed);
    tgt = $signed(it.target_speed);
    res = '0;
    res.motor_out = it.motor;
    reversal = (held_target[m] > 0 && tgt < 0) || (held_target[m] < 0 && tgt > 0);
    if (magnitude(meas) < turn_speed || !reversal) begin
      held_target[m] = tgt;
      sp = tgt;
    end else begin
      // still turning too fast to reverse: coast on the old direction
      sp = 0;
    end
    if (sp > 0) begin
      drive_dir[m] = DIR_FWD;
      duty_rev[m] = 0;
      duty_fwd[m] = clamp_duty(duty_fwd[m] + pid_step(m, sp, meas));
      res.drive_fwd = 1'b1;
      res.compare_value = compare_of(duty_fwd[m], cmp_offset);
      res.compare_written = 1'b1;
    end else if (sp < 0) begin
      drive_dir[m] = DIR_REV;
      duty_fwd[m] = 0;
      duty_rev[m] = clamp_duty(duty_rev[m] + pid_step(m, sp, meas));
      res.drive_rev = 1'b1;
      res.compare_value = compare_of(duty_rev[m], cmp_offset);
      res.compare_written = 1'b1;
    end else if (drive_dir[m] == DIR_FWD) begin
      duty_rev[m] = 0;
      duty_fwd[m] = decayed(duty_fwd[m]);
      res.drive_fwd = 1'b1;
      res.compare_value = compare_of(duty_fwd[m], 0);
      res.compare_written = 1'b1;
    end else if (drive_dir[m] == DIR_REV) begin
      duty_fwd[m] = 0;
      duty_rev[m] = decayed(duty_rev[m]);
      res.drive_rev = 1'b1;
      res.compare_value = compare_of(duty_rev[m], 0);
      res.compare_written = 1'b1;
    end
    expected_drives.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < REPORT_CAP)
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_drives.size() == 0) begin
      report_mismatch("result with nothing pending, motor", got.motor_out, -1);
      return;
    end
    want = expected_drives.pop_front();
    if (got.motor_out !== want.motor_out)
      report_mismatch("motor_out", got.motor_out, want.motor_out);
    if (got.drive_fwd !== want.drive_fwd)
      report_mismatch("drive_fwd", got.drive_fwd, want.drive_fwd);
    if (got.drive_rev !== want.drive_rev)
      report_mismatch("drive_rev", got.drive_rev, want.drive_rev);
    if (got.compare_value !== want.compare_value)
      report_mismatch("compare_value", got.compare_value, want.compare_value);
    if (got.compare_written !== want.compare_written)
      report_mismatch("compare_written", got.compare_written, want.compare_written);
  endtask

  function automatic in_item_t speed_item(input int m, input longint meas, input longint tgt);
    in_item_t it;
    it.motor = MOTOR_BITS'(m);
    it.measured_speed = to_speed(meas);
    it.target_speed = to_speed(tgt);
    return it;
  endfunction

  function automatic in_item_t random_item();
    int m;
    int kind;
    longint mag_t;
    longint tgt;
    longint meas;
    m = $urandom_range(0, MOTOR_COUNT - 1);
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 15) == 0) begin
      mag_t = ($urandom_range(0, 9) == 0) ? pick(1, 32767) : pick(1, 3000);
      plan_speed[m] = $urandom_range(0, 1) ? mag_t : -mag_t;
    end
    tgt = plan_speed[m];
    if (kind < 55) begin
      // following the plan, measured speed somewhere on the way there
      meas = tgt * pick(0, 110) / 100 + pick(-20, 20);
    end else if (kind < 68) begin
      tgt = 0;
      meas = pick(-300, 300);
    end else if (kind < 82) begin
      // reversal request, measured speed around the turn point
      tgt = -plan_speed[m];
      meas = pick(0, turn_speed * 2 + 20);
      if (plan_speed[m] < 0) meas = -meas;
      if ($urandom_range(0, 1)) plan_speed[m] = -plan_speed[m];
    end else begin
      tgt = pick(-32768, 32767);
      meas = pick(-32768, 32767);
    end
    return speed_item(m, meas, tgt);
  endfunction

  task automatic offer(input in_item_t it);
    speed_requests.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_drives.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    repeat (count) offer(random_item());
    wait_idle();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_PROP_GAIN:     kp = val;
      REG_INT_GAIN:      ki = val;
      REG_DERIV_GAIN:    kd = val;
      REG_REVERSE_LIMIT: turn_speed = val[14:0];
      REG_INC_MAX:       inc_hi = $signed(val);
      REG_INC_MIN:       inc_lo = $signed(val);
      REG_DUTY_MAX:      duty_top = val;
      REG_DEAD_OFFSET:   cmp_offset = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(input longint p, input longint i,
                               input longint d, input longint tp,
                               input longint hi, input longint lo,
                               input longint top, input longint off);
    write_reg(REG_PROP_GAIN, 16'(p));
    write_reg(REG_INT_GAIN, 16'(i));
    write_reg(REG_DERIV_GAIN, 16'(d));
    write_reg(REG_REVERSE_LIMIT, {1'b0, tp[14:0]});
    write_reg(REG_INC_MAX, 16'(hi));
    write_reg(REG_INC_MIN, 16'(lo));
    write_reg(REG_DUTY_MAX, 16'(top));
    write_reg(REG_DEAD_OFFSET, 16'(off));
    cfg_wr_en <= 1'b0;
  endtask

  // sender: one transaction at a time from the request queue
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_drive(in_ch.data);
        items_taken++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (speed_requests.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= speed_requests.pop_front();
        send_gap <= draw_gap(send_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
      if ($urandom_range(0, 127) == 0) send_calm <= ~send_calm;
    end
  end

  // receiver: checks each result and stalls at random
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        recv_draw = draw_gap(recv_calm);
        out_ch.ready <= (recv_draw == 0);
        recv_gap <= (recv_draw > 0) ? recv_draw - 1 : 0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if ($urandom_range(0, 127) == 0) recv_calm <= ~recv_calm;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (items_taken >= HOLD_AFTER);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("four_motor_incremental_pid_drive test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no history, clamped drive, coasting on blocked reversals
    offer(speed_item(0, 0, 0));
    offer(speed_item(0, 0, 32767));
    offer(speed_item(0, 1000, 32767));
    offer(speed_item(0, 32767, 32767));
    offer(speed_item(0, 32767, -32768));
    offer(speed_item(0, -32768, -1));
    offer(speed_item(0, 0, 0));
    offer(speed_item(0, 0, -32768));
    offer(speed_item(1, -32768, -32768));
    offer(speed_item(1, 32767, 1));
    offer(speed_item(2, -32768, 0));
    offer(speed_item(2, 5, 200));
    offer(speed_item(2, 5, 200));
    offer(speed_item(2, 190, 200));
    offer(speed_item(3, 32767, -32768));
    offer(speed_item(3, -32768, 32767));
    random_phase(200);

    // top of every range, compare saturates
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                  16'hFFFF, 16'hFFFF);
    offer(speed_item(0, 100, -200));
    offer(speed_item(1, -32768, 300));
    offer(speed_item(1, 32767, -300));
    random_phase(180);

    load_settings(0, 0, 0, 0, 0, 0, 0, 0);
    random_phase(150);

    // crossed increment clamps: the lower one wins
    load_settings(512, 256, 128, 500, -20, 40, 2000, 30);
    random_phase(200);

    repeat (2) begin
      load_settings(pick(0, 2048), pick(0, 1024), pick(0, 512), pick(0, 3000),
                    pick(-50, 2000), pick(-2000, 50), pick(0, 4000), pick(0, 300));
      random_phase(180);
    end

    load_settings($urandom, $urandom, $urandom, $urandom_range(0, 32767),
                  $urandom, $urandom, $urandom, $urandom);
    random_phase(200);

    load_settings(1024, 1024, 0, 0, 100, -100, 1000, 0);
    random_phase(120);

    if (mismatch_count == 0) begin
      $display("four_motor_incremental_pid_drive test passed");
    end else begin
      $display("four_motor_incremental_pid_drive test failed");
    end
    $finish;
  end

endmodule
